// ===== rtl/hwsg_pkg.sv =====
// ----------------------------------------------------------------------------
// hwsg_pkg
// Shared constants, register codes and types for the hashed weighted seed
// generator.
// ----------------------------------------------------------------------------
package hwsg_pkg;

  localparam int NUM_WEIGHTS   = 6;
  localparam int NUM_LANES     = 4;
  localparam int FIN_STAGES    = 4;
  localparam int CHOICE_STAGES = 3;
  localparam int LATENCY       = 3 * FIN_STAGES + CHOICE_STAGES;

  localparam int TYPE_W   = 3;
  localparam int TCOUNT_W = 3;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int SEED_W   = 32;
  localparam int CELL_W   = 24;
  localparam int NUM_W    = 32;
  localparam int VAR_W    = 30;
  localparam int FRAC_W   = 53;

  localparam logic [63:0] GOLDEN      = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_C1      = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_C2      = 64'h94D0_49BB_1331_11EB;
  localparam logic [63:0] STREAM_BASE = 64'h0000_0000_5EED_0001;

  typedef logic [63:0] word_t;

  typedef enum logic [2:0] {
    REG_SEED       = 3'd0,
    REG_TYPE_COUNT = 3'd1,
    REG_WEIGHT0    = 3'd2,
    REG_WEIGHT1    = 3'd3,
    REG_WEIGHT2    = 3'd4,
    REG_WEIGHT3    = 3'd5,
    REG_WEIGHT4    = 3'd6,
    REG_WEIGHT5    = 3'd7
  } reg_idx_t;

endpackage

// ===== rtl/hwsg_fin64.sv =====
// ----------------------------------------------------------------------------
// hwsg_fin64
// Four-stage pipelined 64-bit finaliser: xor-shift, multiply, xor-shift,
// multiply, xor-shift. Each 64-bit product is split into 32-bit partials.
// ----------------------------------------------------------------------------
module hwsg_fin64 (
  input  logic           clk,
  input  logic           en,
  input  hwsg_pkg::word_t x,
  output hwsg_pkg::word_t y
);

  localparam logic [31:0] C1_LO = hwsg_pkg::MIX_C1[31:0];
  localparam logic [31:0] C1_HI = hwsg_pkg::MIX_C1[63:32];
  localparam logic [31:0] C2_LO = hwsg_pkg::MIX_C2[31:0];
  localparam logic [31:0] C2_HI = hwsg_pkg::MIX_C2[63:32];

  hwsg_pkg::word_t xs;
  hwsg_pkg::word_t ll1_nxt, ll1_r;
  logic [31:0]     lh1_nxt, lh1_r, hl1_nxt, hl1_r;
  hwsg_pkg::word_t m1;
  hwsg_pkg::word_t b_nxt, b_r;
  hwsg_pkg::word_t ll2_nxt, ll2_r;
  logic [31:0]     lh2_nxt, lh2_r, hl2_nxt, hl2_r;
  hwsg_pkg::word_t m2;
  hwsg_pkg::word_t c_nxt, c_r;

  always_comb begin
    xs      = x ^ (x >> 30);
    ll1_nxt = 64'(xs[31:0]) * 64'(C1_LO);
    lh1_nxt = xs[31:0] * C1_HI;
    hl1_nxt = xs[63:32] * C1_LO;

    m1    = ll1_r + {lh1_r + hl1_r, 32'b0};
    b_nxt = m1 ^ (m1 >> 27);

    ll2_nxt = 64'(b_r[31:0]) * 64'(C2_LO);
    lh2_nxt = b_r[31:0] * C2_HI;
    hl2_nxt = b_r[63:32] * C2_LO;

    m2    = ll2_r + {lh2_r + hl2_r, 32'b0};
    c_nxt = m2 ^ (m2 >> 31);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll1_r <= ll1_nxt;
      lh1_r <= lh1_nxt;
      hl1_r <= hl1_nxt;
      b_r   <= b_nxt;
      ll2_r <= ll2_nxt;
      lh2_r <= lh2_nxt;
      hl2_r <= hl2_nxt;
      c_r   <= c_nxt;
    end
  end

  assign y = c_r;

endmodule

// ===== rtl/hwsg_cfg.sv =====
// ----------------------------------------------------------------------------
// hwsg_cfg
// APB register file with derived type count, weight sum and cumulative
// weights, registered for the type choice.
// ----------------------------------------------------------------------------
module hwsg_cfg #(
  parameter int MAX_TYPES   = 6,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hwsg_pkg::ADDR_W-1:0]      paddr,
  input  logic [hwsg_pkg::DATA_W-1:0]      pwdata,
  output logic [hwsg_pkg::DATA_W-1:0]      prdata,
  output logic                             pready,
  output logic [hwsg_pkg::SEED_W-1:0]      seed,
  output logic [hwsg_pkg::TCOUNT_W-1:0]    n_types,
  output logic [WEIGHT_BITS+2:0]           wsum,
  output logic [WEIGHT_BITS+2:0]           cum [hwsg_pkg::NUM_WEIGHTS]
);

  localparam int SW = WEIGHT_BITS + 3;

  logic [hwsg_pkg::SEED_W-1:0]   seed_r;
  logic [hwsg_pkg::TCOUNT_W-1:0] type_count_r;
  logic [WEIGHT_BITS-1:0]        weight_r [hwsg_pkg::NUM_WEIGHTS];
  hwsg_pkg::reg_idx_t            idx;
  logic                          wr;

  logic [hwsg_pkg::TCOUNT_W-1:0] n_nxt, n_r;
  logic [SW-1:0]                 sum_nxt, sum_r;
  logic [SW-1:0]                 cum_nxt [hwsg_pkg::NUM_WEIGHTS];
  logic [SW-1:0]                 cum_r   [hwsg_pkg::NUM_WEIGHTS];

  assign idx    = hwsg_pkg::reg_idx_t'(paddr[hwsg_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r       <= '0;
      type_count_r <= '0;
      for (int i = 0; i < hwsg_pkg::NUM_WEIGHTS; i++) begin
        weight_r[i] <= '0;
      end
    end else if (wr) begin
      case (idx)
        hwsg_pkg::REG_SEED:       seed_r       <= pwdata;
        hwsg_pkg::REG_TYPE_COUNT: type_count_r <= pwdata[hwsg_pkg::TCOUNT_W-1:0];
        hwsg_pkg::REG_WEIGHT0:    weight_r[0]  <= pwdata[WEIGHT_BITS-1:0];
        hwsg_pkg::REG_WEIGHT1:    weight_r[1]  <= pwdata[WEIGHT_BITS-1:0];
        hwsg_pkg::REG_WEIGHT2:    weight_r[2]  <= pwdata[WEIGHT_BITS-1:0];
        hwsg_pkg::REG_WEIGHT3:    weight_r[3]  <= pwdata[WEIGHT_BITS-1:0];
        hwsg_pkg::REG_WEIGHT4:    weight_r[4]  <= pwdata[WEIGHT_BITS-1:0];
        hwsg_pkg::REG_WEIGHT5:    weight_r[5]  <= pwdata[WEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      hwsg_pkg::REG_SEED:       prdata = seed_r;
      hwsg_pkg::REG_TYPE_COUNT: prdata = hwsg_pkg::DATA_W'(type_count_r);
      hwsg_pkg::REG_WEIGHT0:    prdata = hwsg_pkg::DATA_W'(weight_r[0]);
      hwsg_pkg::REG_WEIGHT1:    prdata = hwsg_pkg::DATA_W'(weight_r[1]);
      hwsg_pkg::REG_WEIGHT2:    prdata = hwsg_pkg::DATA_W'(weight_r[2]);
      hwsg_pkg::REG_WEIGHT3:    prdata = hwsg_pkg::DATA_W'(weight_r[3]);
      hwsg_pkg::REG_WEIGHT4:    prdata = hwsg_pkg::DATA_W'(weight_r[4]);
      hwsg_pkg::REG_WEIGHT5:    prdata = hwsg_pkg::DATA_W'(weight_r[5]);
      default:                  prdata = '0;
    endcase
  end

  // zero count means one type of weight one; zero sum is taken as one
  always_comb begin
    logic [hwsg_pkg::TCOUNT_W-1:0] cnt;
    logic [SW-1:0]                 acc;
    logic [SW-1:0]                 w_eff;
    cnt = (type_count_r > hwsg_pkg::TCOUNT_W'(MAX_TYPES)) ?
          hwsg_pkg::TCOUNT_W'(MAX_TYPES) : type_count_r;
    acc = '0;
    for (int t = 0; t < hwsg_pkg::NUM_WEIGHTS; t++) begin
      if (type_count_r == '0) begin
        w_eff = (t == 0) ? SW'(1) : '0;
      end else begin
        w_eff = (t < int'(cnt)) ? SW'(weight_r[t]) : '0;
      end
      acc        = acc + w_eff;
      cum_nxt[t] = acc;
    end
    sum_nxt = (acc == '0) ? SW'(1) : acc;
    n_nxt   = (type_count_r == '0) ? hwsg_pkg::TCOUNT_W'(1) : cnt;
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    sum_r <= sum_nxt;
    for (int t = 0; t < hwsg_pkg::NUM_WEIGHTS; t++) begin
      cum_r[t] <= cum_nxt[t];
    end
  end

  assign seed    = seed_r;
  assign n_types = n_r;
  assign wsum    = sum_r;
  assign cum     = cum_r;

endmodule

// ===== rtl/hwsg_choice.sv =====
// ----------------------------------------------------------------------------
// hwsg_choice
// Three-stage weighted type choice: draw times weight sum in two partial
// products, exact sum, then compare against cumulative weights times 2^53.
// ----------------------------------------------------------------------------
module hwsg_choice #(
  parameter int MAX_TYPES   = 6,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [hwsg_pkg::FRAC_W-1:0]      draw,
  input  logic [hwsg_pkg::TCOUNT_W-1:0]    n_types,
  input  logic [WEIGHT_BITS+2:0]           wsum,
  input  logic [WEIGHT_BITS+2:0]           cum [hwsg_pkg::NUM_WEIGHTS],
  output logic [hwsg_pkg::TYPE_W-1:0]      type_id
);

  localparam int SW   = WEIGHT_BITS + 3;
  localparam int LO_W = 32;
  localparam int HI_W = hwsg_pkg::FRAC_W - LO_W;
  localparam int PW   = hwsg_pkg::FRAC_W + SW;

  logic [LO_W+SW-1:0]          p_lo_nxt, p_lo_r;
  logic [HI_W+SW-1:0]          p_hi_nxt, p_hi_r;
  logic [PW-1:0]               prod_nxt, prod_r;
  logic [hwsg_pkg::TYPE_W-1:0] tid_nxt, tid_r;

  always_comb begin
    p_lo_nxt = (LO_W+SW)'(draw[LO_W-1:0]) * (LO_W+SW)'(wsum);
    p_hi_nxt = (HI_W+SW)'(draw[hwsg_pkg::FRAC_W-1:LO_W]) * (HI_W+SW)'(wsum);
    prod_nxt = PW'(p_lo_r) + {p_hi_r, {LO_W{1'b0}}};
  end

  // first type whose cumulative weight exceeds the draw, else type 0
  always_comb begin
    logic hit;
    tid_nxt = '0;
    for (int t = MAX_TYPES - 1; t >= 0; t--) begin
      hit = (t < int'(n_types)) && (prod_r < {cum[t], {hwsg_pkg::FRAC_W{1'b0}}});
      if (hit) begin
        tid_nxt = hwsg_pkg::TYPE_W'(t);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo_r <= p_lo_nxt;
      p_hi_r <= p_hi_nxt;
      prod_r <= prod_nxt;
      tid_r  <= tid_nxt;
    end
  end

  assign type_id = tid_r;

endmodule

// ===== rtl/hashed_weighted_seed_gen.sv =====
// Path: a request passes the seed, cell and stream finalisers, then the type choice.
// Throughput: one request per cycle; three chained four-stage finalisers and a
// three-stage type choice, the whole pipeline frozen while a result waits.
// Reset (synchronous, rst_n low): pipeline valid bits and the configuration
// registers clear to zero; requests are accepted once reset is released.
// ----------------------------------------------------------------------------
// hashed_weighted_seed_gen
// Per-parcel seed generator: four counter hashes give a weighted type choice,
// a variant code and height and style fractions.
// ----------------------------------------------------------------------------
module hashed_weighted_seed_gen #(
  parameter int MAX_TYPES   = 6,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [hwsg_pkg::CELL_W-1:0]      in_parcel_cell,
  input  logic [hwsg_pkg::NUM_W-1:0]       in_parcel_number,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hwsg_pkg::TYPE_W-1:0]      out_type_id,
  output logic [hwsg_pkg::VAR_W-1:0]       out_variant_code,
  output logic [hwsg_pkg::FRAC_W-1:0]      out_height_fraction,
  output logic [hwsg_pkg::FRAC_W-1:0]      out_style_fraction,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hwsg_pkg::ADDR_W-1:0]      paddr,
  input  logic [hwsg_pkg::DATA_W-1:0]      pwdata,
  output logic [hwsg_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);

  localparam int LAT = hwsg_pkg::LATENCY;
  localparam int FS  = hwsg_pkg::FIN_STAGES;
  localparam int CS  = hwsg_pkg::CHOICE_STAGES;
  localparam int SW  = WEIGHT_BITS + 3;

  logic                          adv;
  logic [LAT-1:0]                vld_r;

  logic [hwsg_pkg::SEED_W-1:0]   seed;
  logic [hwsg_pkg::TCOUNT_W-1:0] n_types;
  logic [SW-1:0]                 wsum;
  logic [SW-1:0]                 cum [hwsg_pkg::NUM_WEIGHTS];

  logic [hwsg_pkg::CELL_W-1:0]   cell_r [FS];
  logic [hwsg_pkg::NUM_W-1:0]    num_r  [2*FS];
  logic [hwsg_pkg::VAR_W-1:0]    var_r  [CS];
  logic [hwsg_pkg::FRAC_W-1:0]   hgt_r  [CS];
  logic [hwsg_pkg::FRAC_W-1:0]   sty_r  [CS];

  hwsg_pkg::word_t               x0, f1, x1, f2;
  hwsg_pkg::word_t               x2 [hwsg_pkg::NUM_LANES];
  hwsg_pkg::word_t               h  [hwsg_pkg::NUM_LANES];

  assign adv      = !vld_r[LAT-1] || out_ready;
  assign in_ready = adv && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cell_r[0] <= in_parcel_cell;
      for (int i = 1; i < FS; i++) begin
        cell_r[i] <= cell_r[i-1];
      end
      num_r[0] <= in_parcel_number;
      for (int i = 1; i < 2*FS; i++) begin
        num_r[i] <= num_r[i-1];
      end
      var_r[0] <= h[1][63:64-hwsg_pkg::VAR_W];
      hgt_r[0] <= h[2][63:64-hwsg_pkg::FRAC_W];
      sty_r[0] <= h[3][63:64-hwsg_pkg::FRAC_W];
      for (int i = 1; i < CS; i++) begin
        var_r[i] <= var_r[i-1];
        hgt_r[i] <= hgt_r[i-1];
        sty_r[i] <= sty_r[i-1];
      end
    end
  end

  hwsg_cfg #(
    .MAX_TYPES   (MAX_TYPES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .seed    (seed),
    .n_types (n_types),
    .wsum    (wsum),
    .cum     (cum)
  );

  assign x0 = {32'b0, seed} ^ hwsg_pkg::GOLDEN;

  hwsg_fin64 u_fin_seed (.clk(clk), .en(adv), .x(x0), .y(f1));

  assign x1 = f1 ^ 64'(cell_r[FS-1]);

  hwsg_fin64 u_fin_cell (.clk(clk), .en(adv), .x(x1), .y(f2));

  for (genvar k = 0; k < hwsg_pkg::NUM_LANES; k++) begin : g_lane
    assign x2[k] = f2 ^ (hwsg_pkg::STREAM_BASE + 64'(k) + 64'(num_r[2*FS-1]));
    hwsg_fin64 u_fin_stream (.clk(clk), .en(adv), .x(x2[k]), .y(h[k]));
  end

  hwsg_choice #(
    .MAX_TYPES   (MAX_TYPES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_choice (
    .clk     (clk),
    .en      (adv),
    .draw    (h[0][63:64-hwsg_pkg::FRAC_W]),
    .n_types (n_types),
    .wsum    (wsum),
    .cum     (cum),
    .type_id (out_type_id)
  );

  assign out_valid           = vld_r[LAT-1];
  assign out_variant_code    = var_r[CS-1];
  assign out_height_fraction = hgt_r[CS-1];
  assign out_style_fraction  = sty_r[CS-1];

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted request did not enter the pipeline");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(vld_r[LAT-2]) && $past(adv)))
    else $error("result appeared without a request in the last stage");

  a_type_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_type_id < hwsg_pkg::TYPE_W'(MAX_TYPES)))
    else $error("type choice out of range");

endmodule
